@@ hdl/b64_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64_pkg: shared types and constants for the base64 stream encoder
// Group word handed from the front end to the character serializer, queue
// status, and the sextet-to-character mapping of the standard alphabet.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [7:0]  PAD_CHAR    = 8'h3D;

    // One complete or flushed group of up to three bytes.
    typedef struct packed {
        logic [23:0] group;
        logic [2:0]  nchars;   // data characters before padding, 2..4
        logic        last;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, sextet};
        if (sextet < 6'd26) begin
            c = 8'h41 + v;
        end else if (sextet < 6'd52) begin
            c = 8'h61 + (v - 8'd26);
        end else if (sextet < 6'd62) begin
            c = 8'h30 + (v - 8'd52);
        end else if (sextet == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/b64_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64_stream_if: valid/ready channels of the base64 stream encoder
// Byte channel into the encoder and character channel out of it.
// ----------------------------------------------------------------------------
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

@@ hdl/b64_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64_front: byte collector
// Gathers bytes into groups of three and pushes a group word on every third
// byte or on the last byte of a message.
// ----------------------------------------------------------------------------
module b64_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    b64_in_if.sink                 i_in,
    input  wire b64_pkg::t_q_status i_q_status,
    output logic                   o_push,
    output b64_pkg::t_group        o_push_data
);
    import b64_pkg::*;

    logic [15:0] r_held;
    logic [1:0]  r_cnt;
    logic [15:0] n_held;
    logic [1:0]  n_cnt;
    logic        w_accept;

    assign i_in.ready = !i_q_status.full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_held      = r_held;
        n_cnt       = r_cnt;
        o_push      = 1'b0;
        o_push_data = '0;
        o_push_data.last = i_in.in_last;
        // a count of three is handled like two
        if (r_cnt[1]) begin
            o_push_data.group  = {r_held, i_in.in_byte};
            o_push_data.nchars = 3'd4;
        end else if (r_cnt == 2'd0) begin
            o_push_data.group  = {i_in.in_byte, 16'h0000};
            o_push_data.nchars = 3'd2;
        end else begin
            o_push_data.group  = {r_held[15:8], i_in.in_byte, 8'h00};
            o_push_data.nchars = 3'd3;
        end
        if (w_accept) begin
            if (r_cnt[1] || i_in.in_last) begin
                o_push = 1'b1;
                n_held = '0;
                n_cnt  = 2'd0;
            end else if (r_cnt == 2'd0) begin
                n_held = {i_in.in_byte, 8'h00};
                n_cnt  = 2'd1;
            end else begin
                n_held = {r_held[15:8], i_in.in_byte};
                n_cnt  = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= 2'd0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ hdl/b64_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64_queue: group word queue
// Two-entry FIFO between the byte collector and the character serializer.
// ----------------------------------------------------------------------------
module b64_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire b64_pkg::t_group    i_push_data,
    input  wire logic               i_pop,
    output b64_pkg::t_group         o_head,
    output b64_pkg::t_q_status      o_status
);
    import b64_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_group            r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_entry[r_rd_ptr];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ hdl/b64_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64_back: character serializer
// Turns the queue head into four characters, one per cycle unless stalled,
// into a registered output stage; pops the group as its fourth is loaded.
// ----------------------------------------------------------------------------
module b64_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire b64_pkg::t_group    i_head,
    input  wire b64_pkg::t_q_status i_q_status,
    output logic                    o_pop,
    b64_out_if.source               o_out
);
    import b64_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       w_load;
    logic [5:0] w_sextet;
    logic [7:0] w_char;

    assign w_load = !i_q_status.empty && (!r_valid || o_out.ready);
    assign o_pop  = w_load && (r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    w_sextet = i_head.group[23:18];
            2'd1:    w_sextet = i_head.group[17:12];
            2'd2:    w_sextet = i_head.group[11:6];
            default: w_sextet = i_head.group[5:0];
        endcase
        w_char = ({1'b0, r_idx} < i_head.nchars) ? b64_char(w_sextet) : PAD_CHAR;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= w_char;
            r_last <= (r_idx == 2'd3) && i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_char;
    assign o_out.out_last = r_last;

endmodule
`default_nettype wire

@@ hdl/base64_stream_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder: byte stream to standard base64 characters
// Collects bytes into groups of three and emits four characters per group,
// flushing with '=' padding on the byte marked last.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the two-entry group queue has room;
// characters leave one per cycle, while the receiver is ready, from a registered
// output stage, so a sustained stream takes three bytes per four characters, a
// rate set by the one-character-per-cycle output channel. With the serializer
// idle, the byte that completes or flushes a group writes it into the queue,
// then its first character is registered; else it waits behind queued groups.
// out_last marks the fourth character of a group whose final byte was last.
module base64_stream_encoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    b64_in_if.sink    i_in,
    b64_out_if.source o_out
);
    import b64_pkg::*;

    logic      w_push;
    t_group    w_push_data;
    logic      w_pop;
    t_group    w_head;
    t_q_status w_q_status;

    b64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    b64_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_status    (w_q_status)
    );

    b64_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

@@ hdl/b64_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64_checker: port-level checks for the base64 stream encoder
// Watches the character channel and is bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_char,
    input wire logic       i_out_last
);

    logic w_legal;
    assign w_legal = (i_out_char >= 8'h41 && i_out_char <= 8'h5A) ||
                     (i_out_char >= 8'h61 && i_out_char <= 8'h7A) ||
                     (i_out_char >= 8'h30 && i_out_char <= 8'h39) ||
                     (i_out_char == 8'h2B) || (i_out_char == 8'h2F) ||
                     (i_out_char == 8'h3D);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> w_legal)
        else $error("output character outside base64 alphabet");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a character after '=' in the same group is '=' too, until the group ends
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_char == 8'h3D && !i_out_last
            ##1 i_out_valid |-> i_out_char == 8'h3D || !$past(i_out_valid))
        else $error("data character after padding");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.out_last)
);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: base64_stream_encoder byte-to-character checks
// Drives byte messages through the input channel and scores every output
// character against a local encoder model. Covers the directed corner cases,
// random messages under three idling mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import b64_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_OFF      = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    // sextet i maps to the character at bits [8*(63-i) +: 8]
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    logic i_clk;
    logic i_rst_n;

    b64_in_if  in_ch ();
    b64_out_if out_ch ();

    base64_stream_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // encoder model state
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    t_enc_char   expected_chars[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    int mismatches     = 0;
    int bytes_in       = 0;
    int chars_out      = 0;
    int messages       = 0;
    int full_groups    = 0;
    int flush_one      = 0;
    int flush_two      = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------
    function automatic logic [7:0] sextet_to_char(input logic [5:0] sx);
        return B64_ALPHABET[8*(63 - int'(sx)) +: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [23:0] grp;
        int          nchars;
        t_enc_char   c;
        bytes_in++;
        // a count of three cannot occur; treat it like two
        if (held_count >= 2'd2) begin
            grp    = {held_bytes, b};
            nchars = 4;
            full_groups++;
        end else if (!last) begin
            if (held_count == 2'd0) begin
                held_bytes = {b, 8'h00};
            end else begin
                held_bytes[7:0] = b;
            end
            held_count = held_count + 2'd1;
            return;
        end else if (held_count == 2'd0) begin
            grp    = {b, 16'h0000};
            nchars = 2;
            flush_one++;
        end else begin
            grp    = {held_bytes[15:8], b, 8'h00};
            nchars = 3;
            flush_two++;
        end
        for (int k = 0; k < 4; k++) begin
            c.ch   = (k < nchars) ? sextet_to_char(grp[18 - 6*k +: 6]) : PAD_CHAR;
            c.last = (k == 3) && last;
            expected_chars.push_back(c);
        end
        if (last) begin
            messages++;
        end
        held_bytes = '0;
        held_count = '0;
    endtask

    // ------------------------------------------------------------------
    // Predict on accepted bytes, score accepted characters
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_enc_char want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                encode_byte(in_ch.in_byte, in_ch.in_last);
            end
            if (out_ch.valid && out_ch.ready) begin
                chars_out++;
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: unexpected char 0x%02h last=%0b",
                                 out_ch.out_char, out_ch.out_last);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_char !== want.ch || out_ch.out_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("ERROR: char %0d: expected 0x%02h last=%0b,",
                                     chars_out, want.ch, want.last);
                            $display("       got 0x%02h last=%0b",
                                     out_ch.out_char, out_ch.out_last);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no word moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", QUIET_LIMIT);
            $display("base64_stream_encoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Character receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte sender; returns at the falling edge after the word is taken
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // drop valid so the last word is not taken again, then wait for the output
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 8'h00;
        end else if (r < 20) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    // mostly short messages so every flush length shows up often
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 6);
        end else if (r < 95) begin
            return $urandom_range(7, 20);
        end
        return $urandom_range(21, 40);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // one-byte flushes at the extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two-byte flushes
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        // full group ending a message: all '+'
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        // full group not last (all '/'), then full group last
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b1);
        // full group, then a one-byte flush in the same message
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h61, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input int n_items);
        int sent;
        int len;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            len = pick_length();
            for (int i = 0; i < len; i++) begin
                send_byte(pick_byte(), i == len - 1);
            end
            sent += len;
        end
        wait_drain();
    endtask

    // hold the output long enough for the group queue to fill and stall input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_OFF;
        for (int i = 0; i < 24; i++) begin
            send_byte(pick_byte(), i == 23);
        end
        wait_drain();
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        held_bytes    = '0;
        held_count    = '0;
        i_rst_n       = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_phase(6, 76, 110);
        test_random_phase(76, 6, 110);
        test_random_phase(0, 0, 110);
        test_backpressure();

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Run covered %0d bytes in %0d messages, %0d characters scored",
                 bytes_in, messages, chars_out);
        $display("Groups: %0d full, %0d one-byte, %0d two-byte flushes; %0d mismatches",
                 full_groups, flush_one, flush_two, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("base64_stream_encoder verification clean");
        end else begin
            $display("base64_stream_encoder verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/b64_pkg.sv
hdl/b64_stream_if.sv
hdl/b64_front.sv
hdl/b64_queue.sv
hdl/b64_back.sv
hdl/base64_stream_encoder.sv
hdl/b64_checker.sv
dv/testbench.sv
